// ----- hdl/v4alu_pkg.sv -----
`default_nettype none

package v4alu_pkg;

   // Default number of fraction bits of the fixed-point format.
   localparam int FRAC_BITS_DEFAULT = 16;

   // Iteration counts: one root bit per square-root stage, one quotient bit per divider stage.
   localparam int SQRT_STEPS = 33;
   localparam int DIV_STEPS  = 32;

   // Pipeline stage numbers, counted from the input register (stage 0).
   localparam int STG_SCALAR    = 4;
   localparam int STG_LEN       = STG_SCALAR + SQRT_STEPS;
   localparam int STG_DIV_SETUP = STG_LEN + 1;
   localparam int STG_LAST      = STG_DIV_SETUP + DIV_STEPS;
   localparam int HOLD_DEPTH    = STG_LEN - 1;
   localparam int LATENCY       = STG_LAST + 1;

   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_DIV    = 4'd3,
      OP_DOT    = 4'd4,
      OP_SCALE  = 4'd5,
      OP_NEGATE = 4'd6,
      OP_NORM   = 4'd7,
      OP_LENGTH = 4'd8,
      OP_LENSQ  = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_DIV_ZERO  = 2'd1,
      ERR_NORM_ZERO = 2'd2
   } err_type;

   // What one lane hands to the merging stage at the end of the pipeline.
   typedef struct packed {
      logic signed [31:0] value;
      logic               div_zero;
   } lane_out_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = S32_MAX;
      end else if (v < -66'sd2147483648) begin
         r = S32_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Round half up to the fixed-point grid, then saturate.
   function automatic logic signed [31:0] round_sat(input logic signed [65:0] v,
                                                    input int frac);
      logic signed [65:0] t;
      t = (v + (66'sd1 <<< (frac - 1))) >>> frac;
      return sat32(t);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/v4alu_sqrt.sv -----
`default_nettype none

module v4alu_sqrt import v4alu_pkg::*; (
   input  wire logic        clock,
   input  wire logic [64:0] rad,
   output logic      [32:0] root
);

   logic [65:0] rad_ff [SQRT_STEPS];
   logic [33:0] rem_ff [SQRT_STEPS];
   logic [32:0] res_ff [SQRT_STEPS];
   logic [32:0] root_ff;
   logic [32:0] root_in;

   // One root bit per stage, restoring digit-by-digit method.
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      logic [65:0] rad_prev;
      logic [33:0] rem_prev;
      logic [32:0] res_prev;
      logic [35:0] t;
      logic [35:0] trial;

      if (j == 0) begin : g_first
         assign rad_prev = {1'b0, rad};
         assign rem_prev = '0;
         assign res_prev = '0;
      end else begin : g_next
         assign rad_prev = rad_ff[j-1];
         assign rem_prev = rem_ff[j-1];
         assign res_prev = res_ff[j-1];
      end

      assign t     = {rem_prev, rad_prev[65:64]};
      assign trial = {1'b0, res_prev, 2'b01};

      always_ff @(posedge clock) begin
         rad_ff[j] <= {rad_prev[63:0], 2'b00};
         if (t >= trial) begin
            rem_ff[j] <= 34'(t - trial);
            res_ff[j] <= {res_prev[31:0], 1'b1};
         end else begin
            rem_ff[j] <= t[33:0];
            res_ff[j] <= {res_prev[31:0], 1'b0};
         end
      end
   end

   // Round to nearest: step up when the remainder exceeds the root.
   always_comb begin
      root_in = res_ff[SQRT_STEPS-1];
      if (rem_ff[SQRT_STEPS-1] > {1'b0, res_ff[SQRT_STEPS-1]}) begin
         root_in = res_ff[SQRT_STEPS-1] + 33'd1;
      end
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

`default_nettype wire

// ----- hdl/v4alu_lane.sv -----
`default_nettype none

module v4alu_lane import v4alu_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire op_type             op,
   input  wire logic signed [31:0] a,
   input  wire logic signed [31:0] b,
   input  wire logic signed [31:0] sc,
   input  wire logic        [32:0] len,
   output logic signed      [63:0] prod,
   output lane_out_type            res
);

   localparam int NW = 32 + FRAC_BITS;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] vec;
      logic        [31:0] a_mag;
      logic               a_neg;
      logic        [31:0] b_mag;
      logic               b_neg;
   } hold_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] vec;
      logic               neg;
      logic               a_neg;
      logic               a_nz;
      logic               ovf;
      logic               dzero;
      logic        [32:0] d;
      logic        [32:0] rem;
      logic        [31:0] nlow;
      logic        [31:0] q;
   } div_type;

   logic signed [31:0] mul_opnd;
   logic signed [63:0] prod_ff, prod_in;
   hold_type           s1_ff, s1_in;
   hold_type           hold_ff [HOLD_DEPTH];
   hold_type           hold_in;
   div_type            div_ff [DIV_STEPS+1];
   div_type            setup_in;
   logic      [NW-1:0] num;
   div_type            last;
   logic signed [31:0] quo;

   // Stage 1: multiplier and the saturating add, subtract and negate.
   always_comb begin
      if (op == OP_SCALE) begin
         mul_opnd = sc;
      end else if (op == OP_MUL || op == OP_DOT) begin
         mul_opnd = b;
      end else begin
         mul_opnd = a;
      end
      prod_in     = a * mul_opnd;
      s1_in.op    = op;
      s1_in.a_mag = a[31] ? 32'(-a) : a;
      s1_in.a_neg = a[31];
      s1_in.b_mag = b[31] ? 32'(-b) : b;
      s1_in.b_neg = b[31];
      case (op)
         OP_ADD:    s1_in.vec = sat32(66'(a) + 66'(b));
         OP_SUB:    s1_in.vec = sat32(66'(a) - 66'(b));
         OP_NEGATE: s1_in.vec = sat32(-66'(a));
         default:   s1_in.vec = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      s1_ff   <= s1_in;
   end

   assign prod = prod_ff;

   // Stage 2: round the element product; vector fields unused by the operation go to zero.
   always_comb begin
      hold_in = s1_ff;
      case (s1_ff.op)
         OP_MUL, OP_SCALE:          hold_in.vec = round_sat(66'(prod_ff), FRAC_BITS);
         OP_ADD, OP_SUB, OP_NEGATE: hold_in.vec = s1_ff.vec;
         default:                   hold_in.vec = '0;
      endcase
   end

   // Operands wait here while the length is worked out.
   always_ff @(posedge clock) begin
      hold_ff[0] <= hold_in;
      for (int i = 1; i < HOLD_DEPTH; i++) begin
         hold_ff[i] <= hold_ff[i-1];
      end
   end

   // Divider set-up: pick the divisor and flag quotients that cannot fit in 32 bits.
   always_comb begin
      num            = {hold_ff[HOLD_DEPTH-1].a_mag, {FRAC_BITS{1'b0}}};
      setup_in.op    = hold_ff[HOLD_DEPTH-1].op;
      setup_in.vec   = hold_ff[HOLD_DEPTH-1].vec;
      setup_in.a_neg = hold_ff[HOLD_DEPTH-1].a_neg;
      setup_in.a_nz  = (hold_ff[HOLD_DEPTH-1].a_mag != '0);
      setup_in.d     = (hold_ff[HOLD_DEPTH-1].op == OP_DIV) ?
                       {1'b0, hold_ff[HOLD_DEPTH-1].b_mag} : len;
      setup_in.neg   = (hold_ff[HOLD_DEPTH-1].op == OP_DIV) ?
                       (hold_ff[HOLD_DEPTH-1].a_neg ^ hold_ff[HOLD_DEPTH-1].b_neg) :
                       hold_ff[HOLD_DEPTH-1].a_neg;
      setup_in.dzero = (setup_in.d == '0);
      setup_in.rem   = 33'(num[NW-1:32]);
      setup_in.ovf   = (setup_in.rem >= setup_in.d);
      setup_in.nlow  = num[31:0];
      setup_in.q     = '0;
   end

   always_ff @(posedge clock) begin
      div_ff[0] <= setup_in;
   end

   // One quotient bit per stage, restoring division.
   for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
      logic [33:0] t;
      div_type     nxt;

      always_comb begin
         t        = {div_ff[i-1].rem, div_ff[i-1].nlow[31]};
         nxt      = div_ff[i-1];
         nxt.nlow = {div_ff[i-1].nlow[30:0], 1'b0};
         if (t >= {1'b0, div_ff[i-1].d}) begin
            nxt.rem = 33'(t - {1'b0, div_ff[i-1].d});
            nxt.q   = {div_ff[i-1].q[30:0], 1'b1};
         end else begin
            nxt.rem = t[32:0];
            nxt.q   = {div_ff[i-1].q[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         div_ff[i] <= nxt;
      end
   end

   // Apply the sign to the quotient magnitude and saturate.
   always_comb begin
      last = div_ff[DIV_STEPS];
      if (last.ovf) begin
         quo = last.neg ? S32_MIN : S32_MAX;
      end else if (last.neg) begin
         quo = (last.q > 32'h8000_0000) ? S32_MIN : $signed(~last.q + 32'd1);
      end else begin
         quo = last.q[31] ? S32_MAX : $signed(last.q);
      end

      res.div_zero = (last.op == OP_DIV) && last.dzero;
      case (last.op)
         OP_DIV: begin
            if (last.dzero) begin
               res.value = !last.a_nz ? '0 : (last.a_neg ? S32_MIN : S32_MAX);
            end else begin
               res.value = quo;
            end
         end
         OP_NORM: res.value = last.dzero ? '0 : quo;
         default: res.value = last.vec;
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/vector4_fixed_point_alu.sv -----
// Four-component vector ALU on signed fixed point with FRAC_BITS fraction bits. A transaction
// is taken at each rising edge with start high and busy low; busy is high only while reset is
// asserted, so a new transaction may be started in every cycle. Each result appears on the rsp_
// ports for exactly one cycle, marked by rsp_valid, in the order the transactions arrived.
// Every operation passes through the whole pipeline: the 33-stage square-root pipeline that
// produces the length, followed by the 32-stage divider in each lane that normalise and divide
// share. There is no back-pressure on the results.
`default_nettype none

module vector4_fixed_point_alu import v4alu_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic        [3:0]  req_action,
   input  wire logic signed [31:0] req_a_x,
   input  wire logic signed [31:0] req_a_y,
   input  wire logic signed [31:0] req_a_z,
   input  wire logic signed [31:0] req_a_w,
   input  wire logic signed [31:0] req_b_x,
   input  wire logic signed [31:0] req_b_y,
   input  wire logic signed [31:0] req_b_z,
   input  wire logic signed [31:0] req_b_w,
   input  wire logic signed [31:0] req_scale_factor,
   output logic                    rsp_valid,
   output logic signed      [31:0] rsp_r_x,
   output logic signed      [31:0] rsp_r_y,
   output logic signed      [31:0] rsp_r_z,
   output logic signed      [31:0] rsp_r_w,
   output logic signed      [31:0] rsp_r_scalar,
   output logic             [1:0]  rsp_error_code,
   output logic                    rsp_a_is_zero
);

   typedef struct packed {
      logic               valid;
      op_type             op;
      logic               a_zero;
      logic               len_zero;
      logic signed [31:0] scalar;
   } ctl_type;

   ctl_type            ctl_ff [STG_LAST+1];
   ctl_type            ctl_in [STG_LAST+1];
   logic signed [31:0] a_ff [4];
   logic signed [31:0] b_ff [4];
   logic signed [31:0] sc_ff;
   logic signed [63:0] prod [4];
   lane_out_type       lane_res [4];
   logic signed [64:0] pair_ff [2];
   logic signed [65:0] sum_ff;
   logic        [32:0] len;
   logic               any_dz;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_vec_ff [4];
   logic signed [31:0] rsp_scalar_ff;
   err_type            rsp_err_ff, rsp_err_in;
   logic               rsp_zero_ff;

   assign busy = reset;

   // Control line: follows each transaction down the pipeline and collects the scalar result.
   always_comb begin
      ctl_in[0].valid    = start && !busy;
      ctl_in[0].op       = op_type'(req_action);
      ctl_in[0].a_zero   = (req_a_x == '0) && (req_a_y == '0) &&
                           (req_a_z == '0) && (req_a_w == '0);
      ctl_in[0].len_zero = 1'b0;
      ctl_in[0].scalar   = '0;
      for (int s = 1; s <= STG_LAST; s++) begin
         ctl_in[s] = ctl_ff[s-1];
         if (s == STG_SCALAR &&
             (ctl_ff[s-1].op == OP_DOT || ctl_ff[s-1].op == OP_LENSQ)) begin
            ctl_in[s].scalar = round_sat(sum_ff, FRAC_BITS);
         end
         if (s == STG_DIV_SETUP &&
             (ctl_ff[s-1].op == OP_LENGTH || ctl_ff[s-1].op == OP_NORM)) begin
            ctl_in[s].scalar   = sat32(66'(len));
            ctl_in[s].len_zero = (len == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= STG_LAST; s++) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else begin
            ctl_ff[s] <= ctl_in[s];
         end
      end
   end

   // Input operand register.
   always_ff @(posedge clock) begin
      a_ff[0] <= req_a_x;
      a_ff[1] <= req_a_y;
      a_ff[2] <= req_a_z;
      a_ff[3] <= req_a_w;
      b_ff[0] <= req_b_x;
      b_ff[1] <= req_b_y;
      b_ff[2] <= req_b_z;
      b_ff[3] <= req_b_w;
      sc_ff   <= req_scale_factor;
   end

   // One lane per vector component.
   for (genvar i = 0; i < 4; i++) begin : g_lane
      v4alu_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .op    (ctl_ff[0].op),
         .a     (a_ff[i]),
         .b     (b_ff[i]),
         .sc    (sc_ff),
         .len   (len),
         .prod  (prod[i]),
         .res   (lane_res[i])
      );
   end

   // Registered adder tree over the four lane products.
   always_ff @(posedge clock) begin
      pair_ff[0] <= 65'(prod[0]) + 65'(prod[1]);
      pair_ff[1] <= 65'(prod[2]) + 65'(prod[3]);
      sum_ff     <= 66'(pair_ff[0]) + 66'(pair_ff[1]);
   end

   // Rounded length from the sum of squares.
   v4alu_sqrt u_sqrt (
      .clock (clock),
      .rad   (sum_ff[64:0]),
      .root  (len)
   );

   // Merge the lane results and the error status.
   always_comb begin
      any_dz = lane_res[0].div_zero || lane_res[1].div_zero ||
               lane_res[2].div_zero || lane_res[3].div_zero;
      case (ctl_ff[STG_LAST].op)
         OP_DIV:  rsp_err_in = any_dz ? ERR_DIV_ZERO : ERR_NONE;
         OP_NORM: rsp_err_in = ctl_ff[STG_LAST].len_zero ? ERR_NORM_ZERO : ERR_NONE;
         default: rsp_err_in = ERR_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_ff[STG_LAST].valid;
      end
      for (int i = 0; i < 4; i++) begin
         rsp_vec_ff[i] <= lane_res[i].value;
      end
      rsp_scalar_ff <= ctl_ff[STG_LAST].scalar;
      rsp_err_ff    <= rsp_err_in;
      rsp_zero_ff   <= ctl_ff[STG_LAST].a_zero;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_r_x        = rsp_vec_ff[0];
   assign rsp_r_y        = rsp_vec_ff[1];
   assign rsp_r_z        = rsp_vec_ff[2];
   assign rsp_r_w        = rsp_vec_ff[3];
   assign rsp_r_scalar   = rsp_scalar_ff;
   assign rsp_error_code = rsp_err_ff;
   assign rsp_a_is_zero  = rsp_zero_ff;

endmodule

`default_nettype wire

// ----- hdl/v4alu_checker.sv -----
`default_nettype none

module v4alu_checker import v4alu_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire logic signed [31:0] rsp_r_x,
   input wire logic signed [31:0] rsp_r_y,
   input wire logic signed [31:0] rsp_r_z,
   input wire logic signed [31:0] rsp_r_w,
   input wire logic signed [31:0] rsp_r_scalar,
   input wire logic        [1:0]  rsp_error_code,
   input wire logic               rsp_a_is_zero
);

   // Every result comes from a transaction that was taken with start high and busy low; the
   // result passes the output register before the check sees it.
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY + 1))
      else $error("result without a matching transaction");

   // A zero-length normalise clears every value field.
   a_norm_zero_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_NORM_ZERO |->
         rsp_r_x == '0 && rsp_r_y == '0 && rsp_r_z == '0 && rsp_r_w == '0 &&
         rsp_r_scalar == '0)
      else $error("zero-length normalise left a non-zero field");

   // A zero-length normalise can only come from an all-zero A.
   a_norm_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_NORM_ZERO |-> rsp_a_is_zero)
      else $error("zero-length normalise with non-zero A");

   // The error code never takes the unused encoding.
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code == ERR_NONE || rsp_error_code == ERR_DIV_ZERO ||
                     rsp_error_code == ERR_NORM_ZERO))
      else $error("error code out of range");

endmodule

bind vector4_fixed_point_alu v4alu_checker u_checker (.*);

`default_nettype wire
